@@ sv/mips_ex_pkg.sv @@
// ----------------------------------------------------------------------------
// mips_ex_pkg
// Shared types, codes and constants for the MIPS integer execute block.
// ----------------------------------------------------------------------------
package mips_ex_pkg;

    localparam int STORE_ENTRIES = 64;
    localparam int STORE_IDX_W   = (STORE_ENTRIES > 1) ? $clog2(STORE_ENTRIES) : 1;
    localparam int STORE_FILL_W  = $clog2(STORE_ENTRIES + 1);

    localparam int REG_COUNT = 32;
    localparam int REG_IDX_W = 5;

    localparam logic [REG_IDX_W-1:0] GP_INDEX = 5'd28;
    localparam logic [REG_IDX_W-1:0] SP_INDEX = 5'd29;
    localparam logic [31:0]          GP_RESET = 32'h1000_8000;
    localparam logic [31:0]          SP_RESET = 32'h7fff_fffc;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADDU  = 5'd1,
        OP_SUB   = 5'd2,
        OP_SUBU  = 5'd3,
        OP_AND   = 5'd4,
        OP_OR    = 5'd5,
        OP_NOR   = 5'd6,
        OP_SLT   = 5'd7,
        OP_SLTU  = 5'd8,
        OP_ADDI  = 5'd9,
        OP_ADDIU = 5'd10,
        OP_ANDI  = 5'd11,
        OP_ORI   = 5'd12,
        OP_SLTI  = 5'd13,
        OP_SLTIU = 5'd14,
        OP_SLL   = 5'd15,
        OP_SRL   = 5'd16,
        OP_LW    = 5'd17,
        OP_SW    = 5'd18
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_LOAD_MISS  = 2'd1,
        STATUS_TABLE_FULL = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_LOAD,
        S_DONE
    } state_t;

    // Value a register holds before it is first written.
    function automatic logic [31:0] reg_reset_value(input logic [REG_IDX_W-1:0] idx);
        logic [31:0] v;
        v = 32'd0;
        if (idx == GP_INDEX)
            v = GP_RESET;
        else if (idx == SP_INDEX)
            v = SP_RESET;
        return v;
    endfunction

endpackage

@@ sv/mips_integer_execute_with_store_table.sv @@
// ----------------------------------------------------------------------------
// mips_integer_execute_with_store_table
// Executes decoded MIPS integer instructions against a register file and a
// small associative data store, one instruction at a time.
// ----------------------------------------------------------------------------
// One instruction is taken per input transaction and gives exactly one output
// transaction. An ALU instruction passes through S_EXEC and S_DONE before the
// block is ready again; S_DONE waits until the output register is free. lw and
// sw search the data store one entry per cycle through its single read port,
// examining up to the fill count of entries (at most 64); a load hit then reads
// the data in S_LOAD. A finished result waits in an output register, so the
// next instruction may be accepted while it is still pending on the output
// side.
// ----------------------------------------------------------------------------
module mips_integer_execute_with_store_table
    import mips_ex_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // s_tdata fields from bit 0: op[4:0], src_reg[9:5], tgt_reg[14:10],
    // dst_reg[19:15], imm[35:20], zero fill[39:36]
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,
    // m_tdata fields from bit 0: reg_written[0], dest_index[5:1],
    // result_value[37:6], mem_address[69:38], status[71:70]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata
);

    // Input field unpacking.
    logic [4:0]           in_op;
    logic [REG_IDX_W-1:0] in_src;
    logic [REG_IDX_W-1:0] in_tgt;
    logic [REG_IDX_W-1:0] in_dst;
    logic [15:0]          in_imm;

    assign in_op  = s_tdata[4:0];
    assign in_src = s_tdata[9:5];
    assign in_tgt = s_tdata[14:10];
    assign in_dst = s_tdata[19:15];
    assign in_imm = s_tdata[35:20];

    state_t state_reg, state_next;

    // Captured instruction.
    op_t                  op_reg;
    logic [REG_IDX_W-1:0] src_idx_reg;
    logic [REG_IDX_W-1:0] tgt_idx_reg;
    logic [REG_IDX_W-1:0] dst_idx_reg;
    logic [15:0]          imm_reg;

    // Register file memory with one write and two registered reads.
    logic [31:0]          rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_valid_reg, rf_valid_next;
    logic [31:0]          rf_rd_a_reg, rf_rd_b_reg;
    logic                 rs_vld_reg, rt_vld_reg;
    logic                 rf_we;

    // Data store memories.
    logic [31:0]             sa_mem [STORE_ENTRIES];
    logic [31:0]             sv_mem [STORE_ENTRIES];
    logic [31:0]             sa_rd_reg, sv_rd_reg;
    logic [STORE_FILL_W-1:0] fill_reg, fill_next;
    logic [STORE_FILL_W-1:0] k_reg, k_next;
    logic [STORE_IDX_W-1:0]  cmp_idx_reg, cmp_idx_next;
    logic                    cmp_vld_reg, cmp_vld_next;
    logic                    sa_re, sv_re, sa_we, sv_we;
    logic [STORE_IDX_W-1:0]  st_wa;

    // Result staging.
    logic [31:0]          res_value_reg, res_value_next;
    logic [31:0]          addr_reg, addr_next;
    status_t              res_status_reg, res_status_next;
    logic [REG_IDX_W-1:0] res_dest_reg, res_dest_next;
    logic                 res_write_reg, res_write_next;

    // Output register.
    logic                 out_valid_reg;
    logic                 out_written_reg;
    logic [REG_IDX_W-1:0] out_dest_reg;
    logic [31:0]          out_value_reg;
    logic [31:0]          out_addr_reg;
    status_t              out_status_reg;

    logic        accept;
    logic        out_free;
    logic        is_mem_op;
    logic        hit;
    logic        exhausted;
    logic [31:0] rs_val, rt_val, simm, zimm;
    logic [4:0]  shamt;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    assign rs_val = (src_idx_reg == '0) ? 32'd0 :
                    (rs_vld_reg ? rf_rd_a_reg : reg_reset_value(src_idx_reg));
    assign rt_val = (tgt_idx_reg == '0) ? 32'd0 :
                    (rt_vld_reg ? rf_rd_b_reg : reg_reset_value(tgt_idx_reg));
    assign simm   = {{16{imm_reg[15]}}, imm_reg};
    assign zimm   = {16'd0, imm_reg};
    assign shamt  = imm_reg[4:0];

    assign is_mem_op = (op_reg == OP_LW) || (op_reg == OP_SW);
    assign hit       = cmp_vld_reg && (sa_rd_reg == addr_reg);
    assign exhausted = (k_reg == fill_reg);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                state_next = is_mem_op ? S_SEARCH : S_DONE;
            end
            S_SEARCH:
            begin
                if (hit)
                    state_next = (op_reg == OP_LW) ? S_LOAD : S_DONE;
                else if (exhausted)
                    state_next = S_DONE;
            end
            S_LOAD:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and memory controls
    // ------------------------------------------------------------------
    always_comb
    begin
        res_value_next  = res_value_reg;
        addr_next       = addr_reg;
        res_status_next = res_status_reg;
        res_dest_next   = res_dest_reg;
        res_write_next  = res_write_reg;
        fill_next       = fill_reg;
        k_next          = k_reg;
        cmp_idx_next    = cmp_idx_reg;
        cmp_vld_next    = 1'b0;
        rf_valid_next   = rf_valid_reg;
        sa_re           = 1'b0;
        sv_re           = 1'b0;
        sa_we           = 1'b0;
        sv_we           = 1'b0;
        st_wa           = cmp_idx_reg;
        rf_we           = 1'b0;

        case (state_reg)
            S_EXEC:
            begin
                // The ALU: adds, subtracts, compares, logic operations and shifts.
                res_value_next  = 32'd0;
                addr_next       = 32'd0;
                res_status_next = STATUS_OK;
                res_dest_next   = dst_idx_reg;
                res_write_next  = 1'b1;
                k_next          = '0;
                case (op_reg)
                    OP_ADD, OP_ADDU:   res_value_next = rs_val + rt_val;
                    OP_SUB, OP_SUBU:   res_value_next = rs_val - rt_val;
                    OP_AND:            res_value_next = rs_val & rt_val;
                    OP_OR:             res_value_next = rs_val | rt_val;
                    OP_NOR:            res_value_next = ~(rs_val | rt_val);
                    OP_SLT:  res_value_next = {31'd0, $signed(rs_val) < $signed(rt_val)};
                    OP_SLTU: res_value_next = {31'd0, rs_val < rt_val};
                    OP_ADDI, OP_ADDIU:
                    begin
                        res_value_next = rs_val + simm;
                        res_dest_next  = tgt_idx_reg;
                    end
                    OP_ANDI:
                    begin
                        res_value_next = rs_val & zimm;
                        res_dest_next  = tgt_idx_reg;
                    end
                    OP_ORI:
                    begin
                        res_value_next = rs_val | zimm;
                        res_dest_next  = tgt_idx_reg;
                    end
                    OP_SLTI:
                    begin
                        res_value_next = {31'd0, $signed(rs_val) < $signed(simm)};
                        res_dest_next  = tgt_idx_reg;
                    end
                    OP_SLTIU:
                    begin
                        res_value_next = {31'd0, rs_val < simm};
                        res_dest_next  = tgt_idx_reg;
                    end
                    OP_SLL:            res_value_next = rt_val << shamt;
                    OP_SRL:            res_value_next = rt_val >> shamt;
                    OP_LW:
                    begin
                        addr_next      = rs_val + simm;
                        res_dest_next  = '0;
                        res_write_next = 1'b0;
                    end
                    OP_SW:
                    begin
                        addr_next      = rs_val + simm;
                        res_value_next = rt_val;
                        res_dest_next  = '0;
                        res_write_next = 1'b0;
                    end
                    default:
                    begin
                        res_dest_next  = '0;
                        res_write_next = 1'b0;
                    end
                endcase
                if (res_dest_next == '0)
                    res_write_next = 1'b0;
                if (!res_write_next)
                    res_dest_next = '0;
            end
            S_SEARCH:
            begin
                // One address read is issued per cycle while the previous one
                // is compared.
                if (hit)
                begin
                    if (op_reg == OP_LW)
                    begin
                        sv_re          = 1'b1;
                        res_dest_next  = tgt_idx_reg;
                        res_write_next = (tgt_idx_reg != '0);
                        if (tgt_idx_reg == '0)
                            res_dest_next = '0;
                    end
                    else
                    begin
                        sv_we = 1'b1;
                        st_wa = cmp_idx_reg;
                    end
                end
                else if (exhausted)
                begin
                    if (op_reg == OP_LW)
                    begin
                        res_status_next = STATUS_LOAD_MISS;
                    end
                    else if (fill_reg == STORE_FILL_W'(STORE_ENTRIES))
                    begin
                        res_status_next = STATUS_TABLE_FULL;
                    end
                    else
                    begin
                        sa_we     = 1'b1;
                        sv_we     = 1'b1;
                        st_wa     = fill_reg[STORE_IDX_W-1:0];
                        fill_next = fill_reg + 1'b1;
                    end
                end
                else
                begin
                    sa_re        = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = k_reg[STORE_IDX_W-1:0];
                    k_next       = k_reg + 1'b1;
                end
            end
            S_LOAD:
            begin
                res_value_next = sv_rd_reg;
            end
            S_DONE:
            begin
                if (out_free && res_write_reg)
                begin
                    rf_we                       = 1'b1;
                    rf_valid_next[res_dest_reg] = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rf_valid_reg  <= '0;
            fill_reg      <= '0;
            k_reg         <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rf_valid_reg <= rf_valid_next;
            fill_reg     <= fill_next;
            k_reg        <= k_next;
            cmp_vld_reg  <= cmp_vld_next;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg      <= op_t'(in_op);
            src_idx_reg <= in_src;
            tgt_idx_reg <= in_tgt;
            dst_idx_reg <= in_dst;
            imm_reg     <= in_imm;
            rs_vld_reg  <= rf_valid_reg[in_src];
            rt_vld_reg  <= rf_valid_reg[in_tgt];
        end
        res_value_reg  <= res_value_next;
        addr_reg       <= addr_next;
        res_status_reg <= res_status_next;
        res_dest_reg   <= res_dest_next;
        res_write_reg  <= res_write_next;
        cmp_idx_reg    <= cmp_idx_next;
        if (state_reg == S_DONE && out_free)
        begin
            out_written_reg <= res_write_reg;
            out_dest_reg    <= res_dest_reg;
            out_value_reg   <= res_value_reg;
            out_addr_reg    <= addr_reg;
            out_status_reg  <= res_status_reg;
        end
    end

    // Register file memory.
    always_ff @(posedge clk)
    begin
        if (rf_we)
            rf_mem[res_dest_reg] <= res_value_reg;
        if (accept)
        begin
            rf_rd_a_reg <= rf_mem[in_src];
            rf_rd_b_reg <= rf_mem[in_tgt];
        end
    end

    // Data store memories.
    always_ff @(posedge clk)
    begin
        if (sa_we)
            sa_mem[st_wa] <= addr_reg;
        if (sv_we)
            sv_mem[st_wa] <= res_value_reg;
        if (sa_re)
            sa_rd_reg <= sa_mem[k_reg[STORE_IDX_W-1:0]];
        if (sv_re)
            sv_rd_reg <= sv_mem[cmp_idx_reg];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_status_reg, out_addr_reg, out_value_reg, out_dest_reg,
                       out_written_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= STORE_FILL_W'(STORE_ENTRIES))
        else $error("store fill count beyond table size");

    a_search_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> k_reg <= fill_reg)
        else $error("search index passed the fill count");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_tready)
        else $error("second instruction accepted while one is in flight");

    a_dest_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_written_reg |-> out_dest_reg != '0)
        else $error("register write reported for register zero");

    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg == STATUS_LOAD_MISS
        |-> !out_written_reg && out_value_reg == 32'd0)
        else $error("load miss carries a value or a write");

endmodule
